### rtl/dprt_pkg.sv
// Shared types, constants and codes of the page dirty range tracker.
package dprt_pkg;

    localparam int TRACKED_PAGES_DEF = 64;
    localparam int MAX_SPANS_DEF     = 8;

    localparam int PAGE_W   = 52;
    localparam int LINE_W   = 58;
    localparam int OFS_W    = 12;
    localparam int END_W    = 13;
    localparam int LIMIT_W  = 13;
    localparam int LINES    = 64;
    localparam int LIDX_W   = 6;
    localparam int TOTAL_W  = 14;
    localparam int SPAN_W   = OFS_W + END_W;

    localparam logic [END_W-1:0]   PAGE_BYTES  = 13'd4096;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 13'd3072;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_SYNC  = 1'b1;

    localparam logic CFG_TRACK = 1'b0;
    localparam logic CFG_LIMIT = 1'b1;

    typedef struct packed {
        logic              req_type;
        logic [PAGE_W-1:0] page_number;
        logic [OFS_W-1:0]  range_start;
        logic [END_W-1:0]  range_end;
    } req_t;

    typedef struct packed {
        logic [LINE_W-1:0] line_number;
        logic              line_valid;
        logic [1:0]        status;
        logic              last;
    } rsp_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_MREQ,
        S_MPROC,
        S_MFIN,
        S_SREQ,
        S_SPROC,
        S_EMIT,
        S_RESP
    } state_t;

endpackage

### rtl/dprt_ram.sv
// Simple dual-port synchronous RAM, one write and one registered read port.
module dprt_ram #(
    parameter int W  = 8,
    parameter int AW = 4
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [W-1:0]  wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [W-1:0]  rdata
);

    logic [W-1:0] mem [0:(1<<AW)-1];
    logic [W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // hold the last read word until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/dprt_ctrl.sv
// Sequencer: table scan, span merge, sync mask build and line emission.
module dprt_ctrl import dprt_pkg::*; #(
    parameter int TRACKED_PAGES = TRACKED_PAGES_DEF,
    parameter int MAX_SPANS     = MAX_SPANS_DEF,
    parameter int EW  = (TRACKED_PAGES > 1) ? $clog2(TRACKED_PAGES) : 1,
    parameter int SW  = (MAX_SPANS > 1) ? $clog2(MAX_SPANS) : 1,
    parameter int CW  = $clog2(MAX_SPANS + 1),
    parameter int MW  = PAGE_W + 2 + CW,
    parameter int SAW = EW + 1 + SW
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               track_en,
    input  logic [LIMIT_W-1:0] dirty_limit,
    input  logic               in_valid,
    output logic               in_ready,
    input  req_t               in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output rsp_t               out_data,
    output logic               meta_we,
    output logic [EW-1:0]      meta_waddr,
    output logic [MW-1:0]      meta_wdata,
    output logic               meta_re,
    output logic [EW-1:0]      meta_raddr,
    input  logic [MW-1:0]      meta_rdata,
    output logic               span_we,
    output logic [SAW-1:0]     span_waddr,
    output logic [SPAN_W-1:0]  span_wdata,
    output logic               span_re,
    output logic [SAW-1:0]     span_raddr,
    input  logic [SPAN_W-1:0]  span_rdata
);

    localparam int NW = $clog2(MAX_SPANS + 2);

    state_t state_reg, state_next;
    req_t   req_reg, req_next;
    logic [END_W-1:0]   s_reg, s_next;
    logic [END_W-1:0]   f_reg, f_next;
    logic [EW-1:0]      scan_reg, scan_next;
    logic               free_found_reg, free_found_next;
    logic [EW-1:0]      free_idx_reg, free_idx_next;
    logic [EW-1:0]      ent_reg, ent_next;
    logic               full_reg, full_next;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic               bank_reg, bank_next;
    logic [CW-1:0]      si_reg, si_next;
    logic [NW-1:0]      n_reg, n_next;
    logic               placed_reg, placed_next;
    logic [TOTAL_W-1:0] total_reg, total_next;
    logic [LINES-1:0]   mask_reg, mask_next;
    logic [LIDX_W-1:0]  bit_reg, bit_next;
    logic [1:0]         status_reg, status_next;
    logic [TRACKED_PAGES-1:0] valid_reg, valid_next;
    logic               out_valid_reg, out_valid_next;
    rsp_t               out_data_reg, out_data_next;

    logic [PAGE_W-1:0] rd_page;
    logic              rd_full;
    logic              rd_bank;
    logic [CW-1:0]     rd_cnt;
    logic              scan_hit, scan_end, cur_free, free_any;
    logic [END_W-1:0]  in_f_clamp;
    logic              in_empty;
    logic [END_W-1:0]  sp_b, sp_f, sp_fc;
    logic              overlap, insert_now, n_room, spans_done;
    logic              slot_free, bit_set, last_line;
    logic [LINES-1:0]  rest;
    logic [NW-1:0]     n_eff;
    logic [TOTAL_W-1:0] total_eff;
    logic              full_new;
    logic [LIDX_W-1:0] lo, hi;
    logic [END_W-1:0]  fm1;

    assign rd_page  = meta_rdata[MW-1 -: PAGE_W];
    assign rd_full  = meta_rdata[CW+1];
    assign rd_bank  = meta_rdata[CW];
    assign rd_cnt   = meta_rdata[CW-1:0];

    assign scan_hit = valid_reg[scan_reg] && (rd_page == req_reg.page_number);
    assign scan_end = (scan_reg == EW'(TRACKED_PAGES - 1));
    assign cur_free = !valid_reg[scan_reg];
    assign free_any = free_found_reg || cur_free;

    assign in_f_clamp = (in_data.range_end > PAGE_BYTES) ? PAGE_BYTES : in_data.range_end;
    assign in_empty   = (in_f_clamp <= {1'b0, in_data.range_start});

    assign sp_b  = {1'b0, span_rdata[SPAN_W-1 -: OFS_W]};
    assign sp_f  = span_rdata[END_W-1:0];
    assign sp_fc = (sp_f > PAGE_BYTES) ? PAGE_BYTES : sp_f;

    assign overlap    = (sp_b <= f_reg) && (sp_f >= s_reg);
    assign insert_now = !overlap && !placed_reg && (sp_b > s_reg);
    assign n_room     = (n_reg < NW'(MAX_SPANS));
    assign spans_done = (si_reg == cnt_reg);

    assign slot_free = !out_valid_reg || out_ready;
    assign bit_set   = mask_reg[bit_reg];
    assign rest      = mask_reg >> bit_reg;
    assign last_line = ((rest >> 1) == '0);

    assign n_eff     = placed_reg ? n_reg : n_reg + NW'(1);
    assign total_eff = placed_reg ? total_reg
                                  : total_reg + TOTAL_W'(f_reg - s_reg);
    assign full_new  = (n_eff > NW'(MAX_SPANS)) ||
                       (total_eff > TOTAL_W'(dirty_limit));

    assign fm1 = sp_fc - END_W'(1);
    assign lo  = sp_b[OFS_W-1 -: LIDX_W];
    assign hi  = fm1[OFS_W-1 -: LIDX_W];

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg        <= req_next;
        s_reg          <= s_next;
        f_reg          <= f_next;
        scan_reg       <= scan_next;
        free_found_reg <= free_found_next;
        free_idx_reg   <= free_idx_next;
        ent_reg        <= ent_next;
        full_reg       <= full_next;
        cnt_reg        <= cnt_next;
        bank_reg       <= bank_next;
        si_reg         <= si_next;
        n_reg          <= n_next;
        placed_reg     <= placed_next;
        total_reg      <= total_next;
        mask_reg       <= mask_next;
        bit_reg        <= bit_next;
        status_reg     <= status_next;
        out_data_reg   <= out_data_next;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_data.req_type == REQ_WRITE)
                    begin
                        state_next = (!track_en || in_empty) ? S_RESP : S_SCAN;
                    end
                    else
                    begin
                        state_next = track_en ? S_SCAN : S_EMIT;
                    end
                end
            end
            S_SCAN:
            begin
                if (scan_hit)
                begin
                    if (req_reg.req_type == REQ_WRITE)
                    begin
                        state_next = rd_full ? S_RESP : S_MREQ;
                    end
                    else
                    begin
                        state_next = rd_full ? S_EMIT : S_SREQ;
                    end
                end
                else if (scan_end)
                begin
                    if (req_reg.req_type == REQ_WRITE)
                    begin
                        state_next = free_any ? S_MREQ : S_RESP;
                    end
                    else
                    begin
                        state_next = S_EMIT;
                    end
                end
            end
            S_MREQ:  state_next = spans_done ? S_MFIN : S_MPROC;
            S_MPROC: state_next = insert_now ? S_MPROC : S_MREQ;
            S_MFIN:  state_next = S_RESP;
            S_SREQ:  state_next = spans_done ? S_EMIT : S_SPROC;
            S_SPROC: state_next = S_SREQ;
            S_EMIT:
            begin
                if (slot_free && ((mask_reg == '0) || (bit_set && last_line)))
                begin
                    state_next = S_IDLE;
                end
            end
            S_RESP:
            begin
                if (slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        req_next        = req_reg;
        s_next          = s_reg;
        f_next          = f_reg;
        scan_next       = scan_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        ent_next        = ent_reg;
        full_next       = full_reg;
        cnt_next        = cnt_reg;
        bank_next       = bank_reg;
        si_next         = si_reg;
        n_next          = n_reg;
        placed_next     = placed_reg;
        total_next      = total_reg;
        mask_next       = mask_reg;
        bit_next        = bit_reg;
        status_next     = status_reg;
        valid_next      = valid_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_data_next   = out_data_reg;
        meta_we         = 1'b0;
        meta_waddr      = ent_reg;
        meta_wdata      = {req_reg.page_number, full_new, ~bank_reg,
                           full_new ? CW'(0) : n_eff[CW-1:0]};
        meta_re         = 1'b0;
        meta_raddr      = '0;
        span_we         = 1'b0;
        span_waddr      = {ent_reg, ~bank_reg, n_reg[SW-1:0]};
        span_wdata      = {s_reg[OFS_W-1:0], f_reg};
        span_re         = 1'b0;
        span_raddr      = {ent_reg, bank_reg, si_reg[SW-1:0]};

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    req_next        = in_data;
                    s_next          = {1'b0, in_data.range_start};
                    f_next          = in_f_clamp;
                    scan_next       = '0;
                    free_found_next = 1'b0;
                    mask_next       = '1;
                    bit_next        = '0;
                    status_next     = in_empty ? ST_EMPTY : ST_OK;
                    if (!track_en)
                    begin
                        status_next = ST_OK;
                    end
                    meta_re = 1'b1;
                end
            end
            S_SCAN:
            begin
                si_next     = '0;
                n_next      = '0;
                placed_next = 1'b0;
                total_next  = '0;
                status_next = ST_OK;
                if (scan_hit)
                begin
                    ent_next  = scan_reg;
                    full_next = rd_full;
                    cnt_next  = rd_cnt;
                    bank_next = rd_bank;
                    mask_next = rd_full ? '1 : '0;
                    if (req_reg.req_type == REQ_SYNC)
                    begin
                        valid_next[scan_reg] = 1'b0;
                    end
                end
                else if (scan_end)
                begin
                    mask_next = '0;
                    // only a write allocates an entry for a missing page
                    if (req_reg.req_type == REQ_WRITE && free_any)
                    begin
                        ent_next  = free_found_reg ? free_idx_reg : scan_reg;
                        full_next = 1'b0;
                        cnt_next  = '0;
                        bank_next = 1'b0;
                        valid_next[free_found_reg ? free_idx_reg : scan_reg] = 1'b1;
                    end
                    else if (req_reg.req_type == REQ_WRITE)
                    begin
                        status_next = ST_FULL;
                    end
                end
                else
                begin
                    if (cur_free && !free_found_reg)
                    begin
                        free_found_next = 1'b1;
                        free_idx_next   = scan_reg;
                    end
                    scan_next  = scan_reg + EW'(1);
                    meta_re    = 1'b1;
                    meta_raddr = scan_reg + EW'(1);
                end
            end
            S_MREQ, S_SREQ:
            begin
                span_re = !spans_done;
            end
            S_MPROC:
            begin
                if (overlap)
                begin
                    // absorb the stored span into the new one
                    if (sp_b < s_reg)
                    begin
                        s_next = sp_b;
                    end
                    if (sp_f > f_reg)
                    begin
                        f_next = sp_f;
                    end
                    si_next = si_reg + CW'(1);
                end
                else if (insert_now)
                begin
                    span_we     = n_room;
                    placed_next = 1'b1;
                    n_next      = n_reg + NW'(1);
                    total_next  = total_reg + TOTAL_W'(f_reg - s_reg);
                end
                else
                begin
                    span_we    = n_room;
                    span_wdata = span_rdata;
                    n_next     = n_reg + NW'(1);
                    total_next = total_reg + TOTAL_W'(sp_f - sp_b);
                    si_next    = si_reg + CW'(1);
                end
            end
            S_MFIN:
            begin
                span_we = !placed_reg && n_room;
                meta_we = 1'b1;
            end
            S_SPROC:
            begin
                if (sp_fc > sp_b)
                begin
                    mask_next = mask_reg | (('1 << lo) & ('1 >> (LIDX_W'(LINES - 1) - hi)));
                end
                si_next = si_reg + CW'(1);
            end
            S_EMIT:
            begin
                if (slot_free)
                begin
                    if (mask_reg == '0)
                    begin
                        out_valid_next = 1'b1;
                        out_data_next  = '{line_number: '0, line_valid: 1'b0,
                                          status: ST_OK, last: 1'b1};
                    end
                    else
                    begin
                        if (bit_set)
                        begin
                            out_valid_next = 1'b1;
                            out_data_next  = '{line_number: {req_reg.page_number, bit_reg},
                                              line_valid: 1'b1, status: ST_OK,
                                              last: last_line};
                        end
                        bit_next = bit_reg + LIDX_W'(1);
                    end
                end
            end
            S_RESP:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = '{line_number: '0, line_valid: 1'b0,
                                      status: status_reg, last: 1'b1};
                end
            end
            default:
            begin
                out_valid_next = out_valid_reg && !out_ready;
            end
        endcase
    end

endmodule

### rtl/page_dirty_range_tracker_top.sv
// Top level of the page dirty range tracker: config registers, memories, sequencer.
//
//  channel | direction | handshake             | payload
//  in      | input     | in_valid / in_ready   | in_data (req_t)
//  out     | output    | out_valid / out_ready | out_data (rsp_t)
//  cfg     | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One item at a time. Lookup scans the page table one entry per cycle,
// stopping at a hit or at the last entry; a merge reads each stored span once; a
// sync reads each span and then walks the 64 lines of the page, waiting on a stall.
// Reset clears the entry valid bits; no clearing pass is needed.
// A stalled output holds the sequencer until the result is taken.
module page_dirty_range_tracker_top import dprt_pkg::*; #(
    parameter int TRACKED_PAGES = TRACKED_PAGES_DEF,
    parameter int MAX_SPANS     = MAX_SPANS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  req_t               in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output rsp_t               out_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_index,
    input  logic [LIMIT_W-1:0] cfg_data
);

    localparam int EW  = (TRACKED_PAGES > 1) ? $clog2(TRACKED_PAGES) : 1;
    localparam int SW  = (MAX_SPANS > 1) ? $clog2(MAX_SPANS) : 1;
    localparam int CW  = $clog2(MAX_SPANS + 1);
    localparam int MW  = PAGE_W + 2 + CW;
    localparam int SAW = EW + 1 + SW;

    logic               track_reg;
    logic [LIMIT_W-1:0] limit_reg;

    logic              meta_we, meta_re;
    logic [EW-1:0]     meta_waddr, meta_raddr;
    logic [MW-1:0]     meta_wdata, meta_rdata;
    logic              span_we, span_re;
    logic [SAW-1:0]    span_waddr, span_raddr;
    logic [SPAN_W-1:0] span_wdata, span_rdata;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            track_reg <= 1'b0;
            limit_reg <= LIMIT_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_TRACK: track_reg <= cfg_data[0];
                CFG_LIMIT: limit_reg <= cfg_data;
                default:   track_reg <= track_reg;
            endcase
        end
    end

    dprt_ram #(.W(MW), .AW(EW)) u_meta_ram (
        .clk   (clk),
        .we    (meta_we),
        .waddr (meta_waddr),
        .wdata (meta_wdata),
        .re    (meta_re),
        .raddr (meta_raddr),
        .rdata (meta_rdata)
    );

    dprt_ram #(.W(SPAN_W), .AW(SAW)) u_span_ram (
        .clk   (clk),
        .we    (span_we),
        .waddr (span_waddr),
        .wdata (span_wdata),
        .re    (span_re),
        .raddr (span_raddr),
        .rdata (span_rdata)
    );

    dprt_ctrl #(
        .TRACKED_PAGES (TRACKED_PAGES),
        .MAX_SPANS     (MAX_SPANS)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .track_en    (track_reg),
        .dirty_limit (limit_reg),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data),
        .meta_we     (meta_we),
        .meta_waddr  (meta_waddr),
        .meta_wdata  (meta_wdata),
        .meta_re     (meta_re),
        .meta_raddr  (meta_raddr),
        .meta_rdata  (meta_rdata),
        .span_we     (span_we),
        .span_waddr  (span_waddr),
        .span_wdata  (span_wdata),
        .span_re     (span_re),
        .span_raddr  (span_raddr),
        .span_rdata  (span_rdata)
    );

endmodule

### rtl/dprt_checker.sv
// Port checker for the page dirty range tracker, bound to the top level.
module dprt_checker import dprt_pkg::*; (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input rsp_t out_data
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("output transaction changed while stalled");

    a_null_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.line_valid |-> out_data.last && out_data.line_number == '0)
        else $error("result without a line is not final or carries a line");

    a_line_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.line_valid |-> out_data.status == ST_OK)
        else $error("flushed line carries an error status");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.status == ST_OK || out_data.status == ST_FULL ||
                       out_data.status == ST_EMPTY))
        else $error("undefined status code");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("new transaction taken before the last one finished");

endmodule

bind page_dirty_range_tracker_top dprt_checker u_dprt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
